/* hw/rtl/smvm_pkg.sv */
// Shared constants and types for the sparse matrix-vector multiplier.
`timescale 1ns / 1ps

package smvm_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int VEC_AW       = $clog2(VECTOR_DEPTH);
    localparam int MAX_ROWS     = 65536;
    localparam int DATA_W       = 32;
    localparam int ACC_W        = 64;
    localparam int FRAC_W       = 16;
    localparam int INDEX_W      = 10;
    localparam int ROW_W        = 16;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_ENTRY = 1'b1
    } func_t;

    localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(MAX_ROWS - 1);
    localparam logic [DATA_W-1:0] RES_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] RES_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

/* hw/rtl/sparse_matrix_vector_multiply.sv */
// Top level of the compressed-row sparse matrix-vector multiplier.
`timescale 1ns / 1ps

// One item is accepted in every cycle while the result side keeps up. A vector load is written
// into a 1024 x 32 vector memory at the transfer; a matrix entry reads that memory at the same
// edge, is multiplied in the next stage, accumulated in the one after and rounded into the
// output register, so the last item of a row passes through the read, product, finished-row and
// output registers before its result appears. The accumulator stage is the only loop. The vector
// memory is not cleared after reset: every element must be loaded before an entry reads it.
module sparse_matrix_vector_multiply (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [smvm_pkg::INDEX_W-1:0]        s_vec_index,
    input  logic signed [smvm_pkg::DATA_W-1:0]  s_vec_value,
    input  logic [smvm_pkg::INDEX_W-1:0]        s_col_index,
    input  logic signed [smvm_pkg::DATA_W-1:0]  s_entry_value,
    input  logic signed [smvm_pkg::DATA_W-1:0]  s_row_bias,
    input  logic                                s_has_entry,
    input  logic                                s_row_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [smvm_pkg::DATA_W-1:0]  m_row_result,
    output logic [smvm_pkg::ROW_W-1:0]          m_row_number,
    output logic                                m_saturated
);

    localparam int FRAC_SH = smvm_pkg::FRAC_W;

    logic                               defect_mode_reg;

    logic [smvm_pkg::DATA_W-1:0]        vec_mem [smvm_pkg::VECTOR_DEPTH];
    logic [smvm_pkg::DATA_W-1:0]        rd_data_reg;

    // Read stage
    logic                               r_valid_reg;
    logic                               r_col_ok_reg;
    logic signed [smvm_pkg::DATA_W-1:0] r_entry_reg;
    logic signed [smvm_pkg::DATA_W-1:0] r_bias_reg;
    logic                               r_has_entry_reg;
    logic                               r_row_end_reg;

    // Product stage
    logic                               p_valid_reg;
    logic signed [smvm_pkg::ACC_W-1:0]  p_prod_reg;
    logic signed [smvm_pkg::DATA_W-1:0] p_bias_reg;
    logic                               p_has_entry_reg;
    logic                               p_row_end_reg;

    // Accumulator state
    logic signed [smvm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [smvm_pkg::ACC_W-1:0]  acc_next;
    logic                               acc_sat_reg;
    logic                               acc_sat_next;
    logic                               row_open_reg;
    logic                               row_defect_reg;
    logic                               row_defect_next;
    logic [smvm_pkg::ROW_W-1:0]         row_counter_reg;

    // Finished row stage
    logic                               f_valid_reg;
    logic signed [smvm_pkg::ACC_W-1:0]  f_acc_reg;
    logic                               f_sat_reg;
    logic [smvm_pkg::ROW_W-1:0]         f_row_reg;

    // Output register
    logic                               m_valid_reg;
    logic signed [smvm_pkg::DATA_W-1:0] m_row_result_reg;
    logic signed [smvm_pkg::DATA_W-1:0] m_row_result_next;
    logic [smvm_pkg::ROW_W-1:0]         m_row_number_reg;
    logic                               m_saturated_reg;
    logic                               m_saturated_next;

    logic out_adv;
    logic f_adv;
    logic p_adv;
    logic r_adv;
    logic in_xfer;
    logic is_entry;
    logic p_step;

    logic signed [smvm_pkg::DATA_W-1:0] u_value;
    logic signed [smvm_pkg::ACC_W-1:0]  base;
    logic                               base_sat;
    logic signed [smvm_pkg::ACC_W-1:0]  addend;
    logic signed [smvm_pkg::ACC_W:0]    sum_wide;
    logic signed [smvm_pkg::ACC_W-FRAC_SH:0] round_q;

    assign out_adv  = !m_valid_reg || m_ready;
    assign f_adv    = !f_valid_reg || out_adv;
    assign p_adv    = !p_valid_reg || f_adv;
    assign r_adv    = !r_valid_reg || p_adv;
    assign s_ready  = r_adv;
    assign in_xfer  = s_valid && r_adv;
    assign is_entry = (s_func == smvm_pkg::FUNC_ENTRY);
    assign p_step   = p_valid_reg && f_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            defect_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            defect_mode_reg <= cfg_wdata;
        end
    end

    // Vector memory: one write or one registered read per cycle, and only on a transfer.
    always_ff @(posedge aclk) begin
        if (in_xfer && !is_entry && (32'(s_vec_index) < smvm_pkg::VECTOR_DEPTH)) begin
            vec_mem[s_vec_index[smvm_pkg::VEC_AW-1:0]] <= s_vec_value;
        end
        if (in_xfer && is_entry) begin
            rd_data_reg <= vec_mem[s_col_index[smvm_pkg::VEC_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (r_adv) begin
            r_valid_reg <= s_valid && is_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && is_entry) begin
            r_col_ok_reg    <= (32'(s_col_index) < smvm_pkg::VECTOR_DEPTH);
            r_entry_reg     <= s_entry_value;
            r_bias_reg      <= s_row_bias;
            r_has_entry_reg <= s_has_entry;
            r_row_end_reg   <= s_row_end;
        end
    end

    assign u_value = r_col_ok_reg ? $signed(rd_data_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_adv) begin
            p_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_adv && r_valid_reg) begin
            p_prod_reg      <= r_entry_reg * u_value;
            p_bias_reg      <= r_bias_reg;
            p_has_entry_reg <= r_has_entry_reg;
            p_row_end_reg   <= r_row_end_reg;
        end
    end

    // Defect mode starts rows at the bias and subtracts products; sums saturate at 64 bits.
    always_comb begin
        if (row_open_reg) begin
            base            = acc_reg;
            base_sat        = acc_sat_reg;
            row_defect_next = row_defect_reg;
        end else begin
            base            = defect_mode_reg ?
                              {{(smvm_pkg::ACC_W-smvm_pkg::DATA_W-FRAC_SH){p_bias_reg[smvm_pkg::DATA_W-1]}},
                               p_bias_reg, {FRAC_SH{1'b0}}} : '0;
            base_sat        = 1'b0;
            row_defect_next = defect_mode_reg;
        end
        if (!p_has_entry_reg) begin
            addend = '0;
        end else if (row_defect_next) begin
            addend = -p_prod_reg;
        end else begin
            addend = p_prod_reg;
        end
        sum_wide = {base[smvm_pkg::ACC_W-1], base} + {addend[smvm_pkg::ACC_W-1], addend};
        if (sum_wide[smvm_pkg::ACC_W] != sum_wide[smvm_pkg::ACC_W-1]) begin
            acc_next     = sum_wide[smvm_pkg::ACC_W] ?
                           {1'b1, {(smvm_pkg::ACC_W-1){1'b0}}} :
                           {1'b0, {(smvm_pkg::ACC_W-1){1'b1}}};
            acc_sat_next = 1'b1;
        end else begin
            acc_next     = sum_wide[smvm_pkg::ACC_W-1:0];
            acc_sat_next = base_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg         <= '0;
            acc_sat_reg     <= 1'b0;
            row_open_reg    <= 1'b0;
            row_defect_reg  <= 1'b0;
            row_counter_reg <= '0;
        end else if (p_step) begin
            if (p_row_end_reg) begin
                acc_reg         <= '0;
                acc_sat_reg     <= 1'b0;
                row_open_reg    <= 1'b0;
                row_counter_reg <= (row_counter_reg == smvm_pkg::ROW_LAST) ?
                                   '0 : row_counter_reg + 1'b1;
            end else begin
                acc_reg      <= acc_next;
                acc_sat_reg  <= acc_sat_next;
                row_open_reg <= 1'b1;
            end
            row_defect_reg <= row_defect_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (f_adv) begin
            f_valid_reg <= p_valid_reg && p_row_end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_step && p_row_end_reg) begin
            f_acc_reg <= acc_next;
            f_sat_reg <= acc_sat_next;
            f_row_reg <= row_counter_reg;
        end
    end

    // Round to nearest with ties upwards, then clip to Q16.16.
    assign round_q = $signed(f_acc_reg[smvm_pkg::ACC_W-1:FRAC_SH])
                   + $signed({{(smvm_pkg::ACC_W-FRAC_SH){1'b0}}, f_acc_reg[FRAC_SH-1]});

    always_comb begin
        m_row_result_next = round_q[smvm_pkg::DATA_W-1:0];
        m_saturated_next  = f_sat_reg;
        if (!round_q[smvm_pkg::ACC_W-FRAC_SH]
            && (round_q[smvm_pkg::ACC_W-FRAC_SH-1:smvm_pkg::DATA_W-1] != '0)) begin
            m_row_result_next = smvm_pkg::RES_MAX;
            m_saturated_next  = 1'b1;
        end else if (round_q[smvm_pkg::ACC_W-FRAC_SH]
            && (round_q[smvm_pkg::ACC_W-FRAC_SH-1:smvm_pkg::DATA_W-1] != '1)) begin
            m_row_result_next = smvm_pkg::RES_MIN;
            m_saturated_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && f_valid_reg) begin
            m_row_result_reg <= m_row_result_next;
            m_row_number_reg <= f_row_reg;
            m_saturated_reg  <= m_saturated_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_row_result = m_row_result_reg;
    assign m_row_number = m_row_number_reg;
    assign m_saturated  = m_saturated_reg;

endmodule

/* hw/rtl/smvm_checker.sv */
// Port-level assertions for the sparse matrix-vector multiplier, bound to its top level.
`timescale 1ns / 1ps

module smvm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [smvm_pkg::DATA_W-1:0]  m_row_result,
    input logic [smvm_pkg::ROW_W-1:0]          m_row_number
);

    logic                       seen_reg;
    logic [smvm_pkg::ROW_W-1:0] last_row_reg;
    logic [smvm_pkg::ROW_W-1:0] expect_row;

    assign expect_row = (last_row_reg == smvm_pkg::ROW_LAST) ? '0 : last_row_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            seen_reg     <= 1'b1;
            last_row_reg <= m_row_number;
        end
    end

    // After reset the result channel is empty.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid directly after reset");

    // A stalled result is held.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_result) && $stable(m_row_number))
        else $error("stalled result changed");

    // Row numbers of successive transfers count up and wrap.
    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && seen_reg |-> m_row_number == expect_row)
        else $error("row number out of sequence");

    // The first row after reset is row zero.
    a_first_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !seen_reg |-> m_row_number == '0)
        else $error("first row number is not zero");

endmodule

bind sparse_matrix_vector_multiply smvm_checker u_smvm_checker (.*);
